[rtl/smfp_pkg.sv]
package smfp_pkg;

  localparam logic [7:0] SAME_EXT_TYPE = 8'd251;

  typedef enum logic [9:0] {
    PH_TYPE    = 10'b0000000001,
    PH_OFF_HI  = 10'b0000000010,
    PH_OFF_LO  = 10'b0000000100,
    PH_NLOC_HI = 10'b0000001000,
    PH_NLOC_LO = 10'b0000010000,
    PH_NSTK_HI = 10'b0000100000,
    PH_NSTK_LO = 10'b0001000000,
    PH_TAG     = 10'b0010000000,
    PH_OPD_HI  = 10'b0100000000,
    PH_OPD_LO  = 10'b1000000000
  } phase_t;

  typedef enum logic [2:0] {
    FK_SAME     = 3'd0,
    FK_ONE      = 3'd1,
    FK_ONE_EXT  = 3'd2,
    FK_CHOP     = 3'd3,
    FK_SAME_EXT = 3'd4,
    FK_APPEND   = 3'd5,
    FK_FULL     = 3'd6
  } frame_kind_t;

  typedef enum logic [2:0] {
    RK_HEADER = 3'd0,
    RK_LOCAL  = 3'd1,
    RK_STACK  = 3'd2,
    RK_MARKER = 3'd3,
    RK_ERROR  = 3'd4
  } result_kind_t;

  typedef enum logic {
    ERR_RESERVED_TYPE = 1'b0,
    ERR_BAD_TAG       = 1'b1
  } error_code_t;

  localparam logic [3:0] TAG_OBJECT = 4'd7;
  localparam logic [3:0] TAG_UNINIT = 4'd8;
  localparam logic [3:0] TAG_MAX    = 4'd8;

  typedef struct packed {
    phase_t      phase;
    frame_kind_t current_kind;
    logic [15:0] held_offset;
    logic [15:0] entries_left;
    logic        in_stack_list;
    logic [3:0]  held_tag;
    logic [7:0]  high_byte;
  } state_t;

  typedef struct packed {
    result_kind_t result_kind;
    frame_kind_t  frame_kind;
    logic [15:0]  offset_delta;
    logic [15:0]  item_count;
    logic [3:0]   type_tag;
    logic [15:0]  type_operand;
    error_code_t  error_code;
    logic         frame_done;
  } result_t;

endpackage

[rtl/smfp_if.sv]
interface smfp_byte_if import smfp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface smfp_res_if import smfp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [2:0]  frame_kind;
  logic [15:0] offset_delta;
  logic [15:0] item_count;
  logic [3:0]  type_tag;
  logic [15:0] type_operand;
  logic        error_code;
  logic        frame_done;

  modport source (output valid, output result_kind, output frame_kind, output offset_delta,
                  output item_count, output type_tag, output type_operand,
                  output error_code, output frame_done, input ready);
  modport sink (input valid, input result_kind, input frame_kind, input offset_delta,
                input item_count, input type_tag, input type_operand,
                input error_code, input frame_done, output ready);
endinterface

[rtl/smfp_step.sv]
module smfp_step import smfp_pkg::*; (
  input  state_t     st,
  input  logic [7:0] in_byte,
  output state_t     st_next,
  output logic       has_result,
  output result_t    res
);

  logic [15:0] v16;
  logic [15:0] entry_left;
  logic        entry_done;
  phase_t      entry_phase;
  result_kind_t entry_kind;

  assign v16 = {st.high_byte, in_byte};

  always_comb begin
    entry_left = st.entries_left - 16'd1;
    entry_kind = st.in_stack_list ? RK_STACK : RK_LOCAL;
    if (entry_left == 16'd0) begin
      if (st.current_kind == FK_FULL && !st.in_stack_list) begin
        entry_done  = 1'b0;
        entry_phase = PH_NSTK_HI;
      end else begin
        entry_done  = 1'b1;
        entry_phase = PH_TYPE;
      end
    end else begin
      entry_done  = 1'b0;
      entry_phase = PH_TAG;
    end
  end

  always_comb begin
    st_next    = st;
    has_result = 1'b0;
    res        = '0;
    res.result_kind  = RK_HEADER;
    res.frame_kind   = st.current_kind;
    res.offset_delta = st.held_offset;
    res.error_code   = ERR_RESERVED_TYPE;
    case (st.phase)
      PH_OFF_HI: begin
        st_next.high_byte = in_byte;
        st_next.phase     = PH_OFF_LO;
      end
      PH_NLOC_HI: begin
        st_next.high_byte = in_byte;
        st_next.phase     = PH_NLOC_LO;
      end
      PH_NSTK_HI: begin
        st_next.high_byte = in_byte;
        st_next.phase     = PH_NSTK_LO;
      end
      PH_OPD_HI: begin
        st_next.high_byte = in_byte;
        st_next.phase     = PH_OPD_LO;
      end
      PH_OFF_LO: begin
        st_next.held_offset = v16;
        res.offset_delta    = v16;
        case (st.current_kind)
          FK_ONE_EXT: begin
            st_next.entries_left  = 16'd1;
            st_next.in_stack_list = 1'b1;
            st_next.phase         = PH_TAG;
            has_result            = 1'b1;
            res.frame_kind        = FK_ONE_EXT;
            res.item_count        = 16'd1;
          end
          FK_CHOP: begin
            st_next.phase  = PH_TYPE;
            has_result     = 1'b1;
            res.frame_kind = FK_CHOP;
            res.item_count = st.entries_left;
            res.frame_done = 1'b1;
          end
          FK_APPEND: begin
            st_next.in_stack_list = 1'b0;
            st_next.phase         = PH_TAG;
            has_result            = 1'b1;
            res.frame_kind        = FK_APPEND;
            res.item_count        = st.entries_left;
          end
          FK_FULL: begin
            st_next.phase = PH_NLOC_HI;
          end
          default: begin
            st_next.phase  = PH_TYPE;
            has_result     = 1'b1;
            res.frame_kind = FK_SAME_EXT;
            res.frame_done = 1'b1;
          end
        endcase
      end
      PH_NLOC_LO: begin
        st_next.entries_left  = v16;
        st_next.in_stack_list = 1'b0;
        st_next.phase         = (v16 == 16'd0) ? PH_NSTK_HI : PH_TAG;
        has_result            = 1'b1;
        res.frame_kind        = FK_FULL;
        res.item_count        = v16;
      end
      PH_NSTK_LO: begin
        st_next.entries_left  = v16;
        st_next.in_stack_list = 1'b1;
        st_next.phase         = (v16 == 16'd0) ? PH_TYPE : PH_TAG;
        has_result            = 1'b1;
        res.result_kind       = RK_MARKER;
        res.frame_kind        = FK_FULL;
        res.item_count        = v16;
        res.frame_done        = (v16 == 16'd0);
      end
      PH_TAG: begin
        if (in_byte > {4'd0, TAG_MAX}) begin
          st_next.phase        = PH_TYPE;
          st_next.entries_left = 16'd0;
          has_result           = 1'b1;
          res.result_kind      = RK_ERROR;
          res.error_code       = ERR_BAD_TAG;
          res.frame_done       = 1'b1;
        end else if (in_byte[3:0] == TAG_OBJECT || in_byte[3:0] == TAG_UNINIT) begin
          st_next.held_tag = in_byte[3:0];
          st_next.phase    = PH_OPD_HI;
        end else begin
          st_next.entries_left = entry_left;
          st_next.phase        = entry_phase;
          has_result           = 1'b1;
          res.result_kind      = entry_kind;
          res.type_tag         = in_byte[3:0];
          res.frame_done       = entry_done;
        end
      end
      PH_OPD_LO: begin
        st_next.entries_left = entry_left;
        st_next.phase        = entry_phase;
        has_result           = 1'b1;
        res.result_kind      = entry_kind;
        res.type_tag         = st.held_tag;
        res.type_operand     = v16;
        res.frame_done       = entry_done;
      end
      PH_TYPE: begin
        has_result = 1'b1;
        if (in_byte inside {[8'd0:8'd63]}) begin
          st_next.current_kind = FK_SAME;
          st_next.held_offset  = {8'd0, in_byte};
          st_next.phase        = PH_TYPE;
          res.frame_kind       = FK_SAME;
          res.offset_delta     = {8'd0, in_byte};
          res.frame_done       = 1'b1;
        end else if (in_byte inside {[8'd64:8'd127]}) begin
          st_next.current_kind  = FK_ONE;
          st_next.held_offset   = {8'd0, in_byte - 8'd64};
          st_next.entries_left  = 16'd1;
          st_next.in_stack_list = 1'b1;
          st_next.phase         = PH_TAG;
          res.frame_kind        = FK_ONE;
          res.offset_delta      = {8'd0, in_byte - 8'd64};
          res.item_count        = 16'd1;
        end else if (in_byte inside {[8'd128:8'd246]}) begin
          st_next.current_kind = FK_SAME;
          st_next.held_offset  = 16'd0;
          st_next.entries_left = 16'd0;
          st_next.phase        = PH_TYPE;
          res.result_kind      = RK_ERROR;
          res.frame_kind       = FK_SAME;
          res.offset_delta     = 16'd0;
          res.frame_done       = 1'b1;
        end else begin
          has_result    = 1'b0;
          st_next.phase = PH_OFF_HI;
          if (in_byte == 8'd247) begin
            st_next.current_kind = FK_ONE_EXT;
          end else if (in_byte < SAME_EXT_TYPE) begin
            st_next.current_kind = FK_CHOP;
            st_next.entries_left = {8'd0, SAME_EXT_TYPE - in_byte};
          end else if (in_byte == SAME_EXT_TYPE) begin
            st_next.current_kind = FK_SAME_EXT;
          end else if (in_byte < 8'd255) begin
            st_next.current_kind = FK_APPEND;
            st_next.entries_left = {8'd0, in_byte - SAME_EXT_TYPE};
          end else begin
            st_next.current_kind = FK_FULL;
          end
        end
      end
      default: begin
        st_next.phase = PH_TYPE;
      end
    endcase
  end

endmodule

[rtl/smfp_out_reg.sv]
module smfp_out_reg import smfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  result_t   d,
  output logic      can_load,
  smfp_res_if.source result
);

  logic    valid;
  result_t data;

  assign can_load = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= d;
    end
  end

  assign result.valid        = valid;
  assign result.result_kind  = data.result_kind;
  assign result.frame_kind   = data.frame_kind;
  assign result.offset_delta = data.offset_delta;
  assign result.item_count   = data.item_count;
  assign result.type_tag     = data.type_tag;
  assign result.type_operand = data.type_operand;
  assign result.error_code   = data.error_code;
  assign result.frame_done   = data.frame_done;

endmodule

[rtl/stack_map_frame_parser.sv]
// Stack map frame parser. Takes one byte of a class-file StackMapTable stream per
// request and gives at most one result per byte: a header per frame, one result per
// local or stack entry, a stack-count marker for full frames, or an error for a
// reserved frame type or a verification tag above 8; frame_done marks the last
// result of a frame. A byte is accepted every cycle unless a held result stalls it;
// its result, if any, passes the byte register, one pass of phase logic and then the
// result register, so the only stall is a held result the sink has not taken.
module stack_map_frame_parser import smfp_pkg::*; (
  input logic       clk,
  input logic       rst,
  smfp_byte_if.sink   stream,
  smfp_res_if.source  result
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_adv;
  logic       can_load;
  logic       has_result;
  state_t     st;
  state_t     st_next;
  result_t    res;

  assign s1_adv       = s1_valid && (!has_result || can_load);
  assign stream.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      s1_byte <= stream.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_TYPE, current_kind: FK_SAME, default: '0};
    end else if (s1_adv) begin
      st <= st_next;
    end
  end

  smfp_step u_step (
    .st         (st),
    .in_byte    (s1_byte),
    .st_next    (st_next),
    .has_result (has_result),
    .res        (res)
  );

  smfp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_adv && has_result),
    .d        (res),
    .can_load (can_load),
    .result   (result)
  );

endmodule

[rtl/smfp_checker.sv]
module smfp_checker import smfp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  result_kind,
  input logic [15:0] item_count,
  input logic [3:0]  type_tag,
  input logic [15:0] type_operand,
  input logic        frame_done
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(result_kind) && $stable(item_count)
      && $stable(frame_done))
    else $error("held result changed");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_err_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && result_kind == RK_ERROR |-> frame_done && item_count == 16'd0)
    else $error("error result not closing frame");

  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && result_kind != RK_LOCAL && result_kind != RK_STACK
      |-> type_tag == 4'd0 && type_operand == 16'd0)
    else $error("tag on non-entry result");

endmodule

bind stack_map_frame_parser smfp_checker u_smfp_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .result_kind  (result.result_kind),
  .item_count   (result.item_count),
  .type_tag     (result.type_tag),
  .type_operand (result.type_operand),
  .frame_done   (result.frame_done)
);

[tb/tb_stack_map_frame_parser.sv]
`timescale 1ns / 100ps

module tb_stack_map_frame_parser import smfp_pkg::*; ();

  localparam int RANDOM_BYTES = 600;
  localparam int HOLD_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [7:0] data;
    bit         fixed;
    result_t    want;
  } dir_row_t;

  logic clk;
  logic rst;

  smfp_byte_if byte_ch ();
  smfp_res_if  res_ch ();

  stack_map_frame_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (byte_ch),
    .result (res_ch)
  );

  // parser state
  phase_t      ph;
  frame_kind_t cur_kind;
  logic [15:0] held_off;
  logic [15:0] left;
  logic        in_stack;
  logic [3:0]  held_tag;
  logic [7:0]  hi;

  result_t    pending_results[$];
  dir_row_t   dir_rows[$];
  logic [7:0] frame_bytes[$];

  bit calm;
  bit hold_req;
  bit hold_done;
  int n_fail;
  int n_bytes;
  int n_results;
  int n_err_results;
  int n_frames;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t mk(result_kind_t rk, frame_kind_t fk, logic [15:0] off,
                                 logic [15:0] cnt, logic [3:0] tag, logic [15:0] opd,
                                 error_code_t err, logic done);
    result_t r;
    r.result_kind  = rk;
    r.frame_kind   = fk;
    r.offset_delta = off;
    r.item_count   = cnt;
    r.type_tag     = tag;
    r.type_operand = opd;
    r.error_code   = err;
    r.frame_done   = done;
    return r;
  endfunction

  function automatic void add_byte(logic [7:0] data);
    frame_bytes.insert(frame_bytes.size(), data);
  endfunction

  function automatic void add_row(logic [7:0] data, bit fixed, result_t want);
    dir_row_t row;
    row.data  = data;
    row.fixed = fixed;
    row.want  = want;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void add_pending(result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic result_t take_entry(logic [3:0] tag, logic [15:0] opd);
    result_kind_t rk;
    logic         done;
    if (in_stack) begin
      rk = RK_STACK;
    end else begin
      rk = RK_LOCAL;
    end
    left = left - 16'd1;
    if (left == 16'd0) begin
      if (cur_kind == FK_FULL && !in_stack) begin
        done = 1'b0;
        ph = PH_NSTK_HI;
      end else begin
        done = 1'b1;
        ph = PH_TYPE;
      end
    end else begin
      done = 1'b0;
      ph = PH_TAG;
    end
    return mk(rk, cur_kind, held_off, 16'd0, tag, opd, ERR_RESERVED_TYPE, done);
  endfunction

  function automatic bit predict_byte(input logic [7:0] data, output result_t r);
    logic [15:0] v16;
    v16 = {hi, data};
    r = '0;
    case (ph)
      PH_OFF_HI: begin
        hi = data;
        ph = PH_OFF_LO;
        return 1'b0;
      end
      PH_NLOC_HI: begin
        hi = data;
        ph = PH_NLOC_LO;
        return 1'b0;
      end
      PH_NSTK_HI: begin
        hi = data;
        ph = PH_NSTK_LO;
        return 1'b0;
      end
      PH_OPD_HI: begin
        hi = data;
        ph = PH_OPD_LO;
        return 1'b0;
      end
      PH_OFF_LO: begin
        held_off = v16;
        case (cur_kind)
          FK_ONE_EXT: begin
            left = 16'd1;
            in_stack = 1'b1;
            ph = PH_TAG;
            r = mk(RK_HEADER, FK_ONE_EXT, held_off, 16'd1, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b0);
          end
          FK_CHOP: begin
            ph = PH_TYPE;
            r = mk(RK_HEADER, FK_CHOP, held_off, left, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b1);
          end
          FK_APPEND: begin
            in_stack = 1'b0;
            ph = PH_TAG;
            r = mk(RK_HEADER, FK_APPEND, held_off, left, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b0);
          end
          FK_FULL: begin
            ph = PH_NLOC_HI;
            return 1'b0;
          end
          default: begin
            ph = PH_TYPE;
            r = mk(RK_HEADER, FK_SAME_EXT, held_off, 16'd0, 4'd0, 16'd0, ERR_RESERVED_TYPE,
                   1'b1);
          end
        endcase
        return 1'b1;
      end
      PH_NLOC_LO: begin
        left = v16;
        in_stack = 1'b0;
        if (v16 == 16'd0) begin
          ph = PH_NSTK_HI;
        end else begin
          ph = PH_TAG;
        end
        r = mk(RK_HEADER, FK_FULL, held_off, v16, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b0);
        return 1'b1;
      end
      PH_NSTK_LO: begin
        left = v16;
        in_stack = 1'b1;
        if (v16 == 16'd0) begin
          ph = PH_TYPE;
          r = mk(RK_MARKER, FK_FULL, held_off, 16'd0, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b1);
        end else begin
          ph = PH_TAG;
          r = mk(RK_MARKER, FK_FULL, held_off, v16, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b0);
        end
        return 1'b1;
      end
      PH_TAG: begin
        if (data > TAG_MAX) begin
          ph = PH_TYPE;
          left = 16'd0;
          r = mk(RK_ERROR, cur_kind, held_off, 16'd0, 4'd0, 16'd0, ERR_BAD_TAG, 1'b1);
          return 1'b1;
        end
        if (data == TAG_OBJECT || data == TAG_UNINIT) begin
          held_tag = data[3:0];
          ph = PH_OPD_HI;
          return 1'b0;
        end
        r = take_entry(data[3:0], 16'd0);
        return 1'b1;
      end
      PH_OPD_LO: begin
        r = take_entry(held_tag, v16);
        return 1'b1;
      end
      default: ;
    endcase

    if (data < 8'd64) begin
      cur_kind = FK_SAME;
      held_off = {8'd0, data};
      ph = PH_TYPE;
      r = mk(RK_HEADER, FK_SAME, held_off, 16'd0, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b1);
      return 1'b1;
    end
    if (data < 8'd128) begin
      cur_kind = FK_ONE;
      held_off = {8'd0, data} - 16'd64;
      left = 16'd1;
      in_stack = 1'b1;
      ph = PH_TAG;
      r = mk(RK_HEADER, FK_ONE, held_off, 16'd1, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b0);
      return 1'b1;
    end
    if (data < 8'd247) begin
      cur_kind = FK_SAME;
      held_off = 16'd0;
      left = 16'd0;
      ph = PH_TYPE;
      r = mk(RK_ERROR, FK_SAME, 16'd0, 16'd0, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b1);
      return 1'b1;
    end
    if (data == 8'd247) begin
      cur_kind = FK_ONE_EXT;
    end else if (data < SAME_EXT_TYPE) begin
      cur_kind = FK_CHOP;
      left = {8'd0, SAME_EXT_TYPE - data};
    end else if (data == SAME_EXT_TYPE) begin
      cur_kind = FK_SAME_EXT;
    end else if (data < 8'd255) begin
      cur_kind = FK_APPEND;
      left = {8'd0, data - SAME_EXT_TYPE};
    end else begin
      cur_kind = FK_FULL;
    end
    ph = PH_OFF_HI;
    return 1'b0;
  endfunction

  function automatic void push_rand(int n);
    for (int i = 0; i < n; i++) begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void push_vtype();
    int t;
    t = $urandom_range(0, 8);
    add_byte(8'(t));
    if (t == TAG_OBJECT || t == TAG_UNINIT) begin
      push_rand(2);
    end
  endfunction

  // returns 1 when the list was cut short by a bad tag
  function automatic bit push_list(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        add_byte(8'($urandom_range(9, 255)));
        return 1'b1;
      end
      push_vtype();
    end
    return 1'b0;
  endfunction

  function automatic void build_frame();
    int sel;
    int n;
    int k;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      add_byte(8'($urandom_range(0, 63)));
    end else if (sel < 30) begin
      add_byte(8'($urandom_range(64, 127)));
      void'(push_list(1));
    end else if (sel < 38) begin
      add_byte(8'd247);
      push_rand(2);
      void'(push_list(1));
    end else if (sel < 48) begin
      add_byte(8'($urandom_range(248, 250)));
      push_rand(2);
    end else if (sel < 55) begin
      add_byte(SAME_EXT_TYPE);
      push_rand(2);
    end else if (sel < 70) begin
      n = $urandom_range(252, 254);
      add_byte(8'(n));
      push_rand(2);
      void'(push_list(n - SAME_EXT_TYPE));
    end else if (sel < 90) begin
      add_byte(8'd255);
      push_rand(2);
      n = $urandom_range(0, 4);
      add_byte(8'd0);
      add_byte(8'(n));
      if (!push_list(n)) begin
        n = $urandom_range(0, 4);
        add_byte(8'd0);
        add_byte(8'(n));
        void'(push_list(n));
      end
    end else if (sel < 94) begin
      add_byte(8'($urandom_range(128, 246)));
    end else if (sel < 97) begin
      // huge local count, cut off by a bad tag
      add_byte(8'd255);
      push_rand(2);
      add_byte(8'($urandom_range(1, 255)));
      push_rand(1);
      k = $urandom_range(0, 3);
      for (int i = 0; i < k; i++) begin
        push_vtype();
      end
      add_byte(8'($urandom_range(9, 255)));
    end else begin
      push_rand($urandom_range(1, 3));
    end
  endfunction

  task automatic send_byte(input logic [7:0] data, input bit fixed, input result_t want);
    result_t pred;
    bit      has;
    while (!calm && $urandom_range(0, 99) < 14) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid   = 1'b1;
    byte_ch.in_byte = data;
    do @(posedge clk); while (!byte_ch.ready);
    has = predict_byte(data, pred);
    if (fixed) begin
      add_pending(want);
    end else if (has) begin
      add_pending(pred);
    end
    n_bytes++;
    @(negedge clk);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (res_ch.result_kind == RK_ERROR) n_err_results++;
      if (res_ch.frame_done) n_frames++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none got kind %0d frame %0d off %0d",
                 $time, res_ch.result_kind, res_ch.frame_kind, res_ch.offset_delta);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", 16'(want.result_kind), 16'(res_ch.result_kind));
        check_field("frame_kind", 16'(want.frame_kind), 16'(res_ch.frame_kind));
        check_field("offset_delta", want.offset_delta, res_ch.offset_delta);
        check_field("item_count", want.item_count, res_ch.item_count);
        check_field("type_tag", 16'(want.type_tag), 16'(res_ch.type_tag));
        check_field("type_operand", want.type_operand, res_ch.type_operand);
        check_field("error_code", 16'(want.error_code), 16'(res_ch.error_code));
        check_field("frame_done", 16'(want.frame_done), 16'(res_ch.frame_done));
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req  = 1'b0;
        hold_done = 1'b1;
      end else begin
        res_ch.ready = calm || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("stack_map_frame_parser: mismatch");
    $finish;
  end

  initial begin : stimulus
    int n_random;
    int wait_cnt;
    rst             = 1'b1;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = 8'd0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    hold_done       = 1'b0;
    n_fail          = 0;
    n_bytes         = 0;
    n_results       = 0;
    n_err_results   = 0;
    n_frames        = 0;
    n_random        = 0;
    ph              = PH_TYPE;
    cur_kind        = FK_SAME;
    held_off        = 16'd0;
    left            = 16'd0;
    in_stack        = 1'b0;
    held_tag        = 4'd0;
    hi              = 8'd0;

    add_row(8'd0, 1'b1,
      mk(RK_HEADER, FK_SAME, 16'd0, 16'd0, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b1));
    add_row(8'd63, 1'b1,
      mk(RK_HEADER, FK_SAME, 16'd63, 16'd0, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b1));
    add_row(8'd127, 1'b1,
      mk(RK_HEADER, FK_ONE, 16'd63, 16'd1, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b0));
    add_row(8'd7, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row(8'hFF, 1'b1,
      mk(RK_STACK, FK_ONE, 16'd63, 16'd0, TAG_OBJECT, 16'hFFFF, ERR_RESERVED_TYPE, 1'b1));
    add_row(8'd128, 1'b1,
      mk(RK_ERROR, FK_SAME, 16'd0, 16'd0, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b1));
    add_row(8'd246, 1'b1,
      mk(RK_ERROR, FK_SAME, 16'd0, 16'd0, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b1));
    add_row(8'd247, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row(8'hFF, 1'b1,
      mk(RK_HEADER, FK_ONE_EXT, 16'hFFFF, 16'd1, 4'd0, 16'd0, ERR_RESERVED_TYPE, 1'b0));
    add_row(8'hFF, 1'b1,
      mk(RK_ERROR, FK_ONE_EXT, 16'hFFFF, 16'd0, 4'd0, 16'd0, ERR_BAD_TAG, 1'b1));
    add_row(8'd248, 1'b0, '0);
    add_row(8'd0, 1'b0, '0);
    add_row(8'd0, 1'b0, '0);
    add_row(SAME_EXT_TYPE, 1'b0, '0);
    add_row(8'd0, 1'b0, '0);
    add_row(8'd1, 1'b0, '0);
    add_row(8'd252, 1'b0, '0);
    add_row(8'd0, 1'b0, '0);
    add_row(8'd2, 1'b0, '0);
    add_row(8'd8, 1'b0, '0);
    add_row(8'h80, 1'b0, '0);
    add_row(8'd0, 1'b0, '0);
    // full frame, no locals and no stack
    add_row(8'd255, 1'b0, '0);
    for (int i = 0; i < 6; i++) begin
      add_row(8'd0, 1'b0, '0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].fixed, dir_rows[i].want);
    end

    while (n_random < RANDOM_BYTES) begin
      build_frame();
      while (frame_bytes.size() != 0) begin
        if (n_random == 150) hold_req = 1'b1;
        calm = (n_random >= 300 && n_random < 400);
        send_byte(frame_bytes.pop_front(), 1'b0, '0);
        n_random++;
      end
    end
    calm          = 1'b0;
    byte_ch.valid = 1'b0;

    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < 2000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      n_fail++;
    end

    $display("run: %0d bytes in, %0d results checked, %0d of them errors, %0d frames closed",
             n_bytes, n_results, n_err_results, n_frames);
    $display("run: receiver hold-off of %0d cycles %0s, %0d field errors",
             HOLD_CYCLES, hold_done ? "done" : "not reached", n_fail);
    if (n_fail == 0) begin
      $display("stack_map_frame_parser: match");
    end else begin
      $display("stack_map_frame_parser: mismatch");
    end
    $finish;
  end

endmodule
